/* src/esp_pkg.sv */
`default_nettype none

package esp_pkg;

  // Input beat payload, command in the lowest bits.
  typedef struct packed {
    logic       hold_neg;
    logic       hold_pos;
    logic       index_pulse;
    logic       mech_switch;
    logic       end_neg_switch;
    logic       end_pos_switch;
    logic       enc_b;
    logic       enc_a;
    logic [2:0] command;
  } esp_item_t;

  localparam int unsigned ItemBits = $bits(esp_item_t);
  localparam int unsigned InDataBits = 16;
  localparam int unsigned OutDataBits = 48;
  localparam int unsigned PosBits = 32;
  localparam int unsigned CfgAddrBits = 3;
  localparam int unsigned CfgDataBits = 24;
  localparam int unsigned TargetBits = 22;
  localparam int unsigned SettleTicksBits = 24;
  localparam logic [7:0] FullDuty = 8'd255;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_MOVE     = 3'd1,
    CMD_HOME     = 3'd2,
    CMD_END_POS  = 3'd3,
    CMD_END_NEG  = 3'd4,
    CMD_STOP     = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_FAR     = 4'd1,
    PH_MID     = 4'd2,
    PH_SLOW    = 4'd3,
    PH_LEAVE   = 4'd4,
    PH_SEEK    = 4'd5,
    PH_SETTLE  = 4'd6,
    PH_SEARCH  = 4'd7,
    PH_END_POS = 4'd8,
    PH_END_NEG = 4'd9
  } phase_t;

  // Bit 0 is bridge input A, bit 1 is bridge input B.
  typedef enum logic [1:0] {
    BR_STOP = 2'b00,
    BR_POS  = 2'b01,
    BR_NEG  = 2'b10
  } bridge_t;

  typedef enum logic [2:0] {
    REG_TARGET  = 3'd0,
    REG_FAR_WIN = 3'd1,
    REG_NEAR_WIN = 3'd2,
    REG_FAR_DUTY = 3'd3,
    REG_MID_DUTY = 3'd4,
    REG_SLOW_DUTY = 3'd5,
    REG_SEARCH_DUTY = 3'd6,
    REG_SETTLE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [TargetBits-1:0] target_counts;
    logic [15:0]                  far_window;
    logic [15:0]                  near_window;
    logic [7:0]                   far_duty;
    logic [7:0]                   mid_duty;
    logic [7:0]                   slow_duty;
    logic [7:0]                   search_duty;
    logic [SettleTicksBits-1:0]   settle_ticks;
  } esp_cfg_t;

  // Sequencer to encoder counter controls.
  typedef struct packed {
    logic count_en;
    logic clear;
  } esp_cnt_ctl_t;

endpackage

`default_nettype wire

/* src/esp_cfg.sv */
`default_nettype none

module esp_cfg
  import esp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CfgAddrBits-1:0] cfg_addr,
  input  wire logic [CfgDataBits-1:0] cfg_wdata,
  output esp_cfg_t                    cfg_r
);

  esp_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_TARGET:      cfg_nxt.target_counts = cfg_wdata[TargetBits-1:0];
        REG_FAR_WIN:     cfg_nxt.far_window = cfg_wdata[15:0];
        REG_NEAR_WIN:    cfg_nxt.near_window = cfg_wdata[15:0];
        REG_FAR_DUTY:    cfg_nxt.far_duty = cfg_wdata[7:0];
        REG_MID_DUTY:    cfg_nxt.mid_duty = cfg_wdata[7:0];
        REG_SLOW_DUTY:   cfg_nxt.slow_duty = cfg_wdata[7:0];
        REG_SEARCH_DUTY: cfg_nxt.search_duty = cfg_wdata[7:0];
        REG_SETTLE:      cfg_nxt.settle_ticks = cfg_wdata[SettleTicksBits-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_counts <= '0;
      cfg_r.far_window    <= 16'd5000;
      cfg_r.near_window   <= 16'd1000;
      cfg_r.far_duty      <= 8'd40;
      cfg_r.mid_duty      <= 8'd37;
      cfg_r.slow_duty     <= 8'd33;
      cfg_r.search_duty   <= 8'd35;
      cfg_r.settle_ticks  <= 24'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/esp_quad.sv */
`default_nettype none

module esp_quad
  import esp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           advance,
  input  wire logic                           enc_a,
  input  wire logic                           enc_b,
  input  wire esp_cnt_ctl_t                   ctl,
  output logic signed [COUNT_WIDTH-1:0]       count_cnt,
  output logic signed [COUNT_WIDTH-1:0]       count_r,
  output logic                                count_error_r
);

  localparam logic signed [COUNT_WIDTH-1:0] CntMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CntMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  logic                          prev_a_r, prev_b_r;
  logic                          chg_a, chg_b, both, up, dn;
  logic signed [COUNT_WIDTH-1:0] count_nxt;

  always_comb begin
    chg_a = enc_a ^ prev_a_r;
    chg_b = enc_b ^ prev_b_r;
    both  = chg_a & chg_b;
    up    = 1'b0;
    dn    = 1'b0;
    if (!both && ctl.count_en) begin
      if (chg_a) begin
        up = (enc_a == enc_b);
        dn = (enc_a != enc_b);
      end else if (chg_b) begin
        up = (enc_a != enc_b);
        dn = (enc_a == enc_b);
      end
    end
    count_cnt = count_r;
    if (up && count_r != CntMax) count_cnt = count_r + COUNT_WIDTH'(1);
    if (dn && count_r != CntMin) count_cnt = count_r - COUNT_WIDTH'(1);
    // A move start overrides whatever was counted this beat
    count_nxt = ctl.clear ? '0 : count_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r      <= 1'b0;
      prev_b_r      <= 1'b0;
      count_r       <= '0;
      count_error_r <= 1'b0;
    end else if (advance) begin
      prev_a_r      <= enc_a;
      prev_b_r      <= enc_b;
      count_r       <= count_nxt;
      count_error_r <= both;
    end
  end

endmodule

`default_nettype wire

/* src/esp_seq.sv */
`default_nettype none

module esp_seq
  import esp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH  = 32,
  parameter int unsigned SETTLE_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire esp_item_t                     item,
  input  wire esp_cfg_t                      cfg,
  input  wire logic signed [COUNT_WIDTH-1:0] count_cnt,
  output esp_cnt_ctl_t                       ctl,
  output bridge_t                            bridge_r,
  output logic [7:0]                         duty_r,
  output logic                               busy
);

  localparam int unsigned CmpW = ((COUNT_WIDTH > TargetBits + 2) ?
                                  COUNT_WIDTH : TargetBits + 2) + 1;
  localparam int unsigned SetW = (SETTLE_WIDTH > SettleTicksBits) ?
                                 SETTLE_WIDTH : SettleTicksBits;

  phase_t                    phase_r, phase_nxt;
  logic                      move_dir_r, move_dir_nxt;
  logic                      count_en_r, count_en_nxt;
  logic [SETTLE_WIDTH-1:0]   settle_r, settle_nxt, settle_load;
  bridge_t                   bridge_nxt;
  logic [7:0]                duty_nxt;
  logic                      started, clear, hold;
  logic signed [CmpW-1:0]    c_x, t_x, win_x, lo_x, hi_x;
  logic                      before_win, before_tgt;
  logic [SetW-1:0]           ticks_x, lim_x;

  always_comb begin
    c_x   = CmpW'(count_cnt);
    t_x   = CmpW'(cfg.target_counts);
    win_x = (phase_r == PH_FAR) ? CmpW'(cfg.far_window) : CmpW'(cfg.near_window);
    lo_x  = t_x - win_x;
    hi_x  = t_x + win_x;
    before_win = move_dir_r ? (c_x < lo_x) : (c_x > hi_x);
    before_tgt = move_dir_r ? (c_x <= t_x) : (c_x >= t_x);
    hold  = move_dir_r ? item.hold_pos : item.hold_neg;
    ticks_x = SetW'(cfg.settle_ticks);
    lim_x   = SetW'({SETTLE_WIDTH{1'b1}});
    settle_load = SETTLE_WIDTH'((ticks_x > lim_x) ? lim_x : ticks_x);
  end

  always_comb begin
    phase_nxt    = phase_r;
    move_dir_nxt = move_dir_r;
    count_en_nxt = count_en_r;
    settle_nxt   = settle_r;
    bridge_nxt   = bridge_r;
    duty_nxt     = duty_r;
    started      = 1'b0;
    clear        = 1'b0;

    if (cmd_t'(item.command) == CMD_STOP) begin
      started    = 1'b1;
      bridge_nxt = BR_STOP;
      phase_nxt  = PH_IDLE;
    end else if (phase_r == PH_IDLE) begin
      case (cmd_t'(item.command))
        CMD_MOVE: begin
          started      = 1'b1;
          clear        = 1'b1;
          count_en_nxt = 1'b1;
          phase_nxt    = PH_FAR;
          move_dir_nxt = (cfg.target_counts > 0);
          bridge_nxt   = (cfg.target_counts > 0) ? BR_POS : BR_NEG;
          duty_nxt     = cfg.far_duty;
        end
        CMD_HOME: begin
          started      = 1'b1;
          count_en_nxt = 1'b0;
          move_dir_nxt = item.mech_switch;
          phase_nxt    = item.mech_switch ? PH_LEAVE : PH_SEEK;
          bridge_nxt   = item.mech_switch ? BR_POS : BR_NEG;
          duty_nxt     = FullDuty;
        end
        CMD_END_POS: begin
          started      = 1'b1;
          count_en_nxt = 1'b0;
          phase_nxt    = PH_END_POS;
          bridge_nxt   = BR_POS;
          duty_nxt     = FullDuty;
        end
        CMD_END_NEG: begin
          started      = 1'b1;
          count_en_nxt = 1'b0;
          phase_nxt    = PH_END_NEG;
          bridge_nxt   = BR_NEG;
          duty_nxt     = FullDuty;
        end
        default: started = 1'b0;
      endcase
    end

    if (!started) begin
      case (phase_r)
        PH_IDLE: phase_nxt = PH_IDLE;
        PH_FAR: begin
          if (!before_win && !hold) begin
            phase_nxt = PH_MID;
            duty_nxt  = cfg.mid_duty;
          end
        end
        PH_MID: begin
          if (!before_win && !hold) begin
            phase_nxt = PH_SLOW;
            duty_nxt  = cfg.slow_duty;
          end
        end
        PH_SLOW: begin
          if (!before_tgt && !hold) begin
            phase_nxt  = PH_IDLE;
            bridge_nxt = BR_STOP;
          end
        end
        PH_LEAVE, PH_SEEK: begin
          if ((phase_r == PH_LEAVE) ? !item.mech_switch : item.mech_switch) begin
            bridge_nxt = BR_STOP;
            settle_nxt = settle_load;
            phase_nxt  = PH_SETTLE;
          end
        end
        PH_SETTLE: begin
          if (settle_r == '0) begin
            phase_nxt  = PH_SEARCH;
            bridge_nxt = BR_POS;
            duty_nxt   = cfg.search_duty;
          end else begin
            settle_nxt = settle_r - SETTLE_WIDTH'(1);
          end
        end
        PH_SEARCH: begin
          if (item.index_pulse) begin
            if (move_dir_r) begin
              // started from the far side of the switch: home again
              count_en_nxt = 1'b0;
              move_dir_nxt = item.mech_switch;
              phase_nxt    = item.mech_switch ? PH_LEAVE : PH_SEEK;
              bridge_nxt   = item.mech_switch ? BR_POS : BR_NEG;
              duty_nxt     = FullDuty;
            end else begin
              phase_nxt  = PH_IDLE;
              bridge_nxt = BR_STOP;
            end
          end
        end
        PH_END_POS: begin
          if (item.end_pos_switch) begin
            phase_nxt  = PH_IDLE;
            bridge_nxt = BR_STOP;
          end
        end
        PH_END_NEG: begin
          if (item.end_neg_switch) begin
            phase_nxt  = PH_IDLE;
            bridge_nxt = BR_STOP;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    ctl.count_en = count_en_r;
    ctl.clear    = clear;
    busy         = (phase_r != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      move_dir_r <= 1'b0;
      count_en_r <= 1'b1;
      settle_r   <= '0;
      bridge_r   <= BR_STOP;
      duty_r     <= '0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      move_dir_r <= move_dir_nxt;
      count_en_r <= count_en_nxt;
      settle_r   <= settle_nxt;
      bridge_r   <= bridge_nxt;
      duty_r     <= duty_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/encoder_stage_positioner.sv */
// An accepted beat is held in the input register, then its result in the state.
// Throughput: one beat per cycle unless out_ stalls; the whole tick (decode, count,
//   sequencer step) is one short combinational pass from input register to state.
// Reset: rst_n synchronous, active low; drops both valid flags, loads register
//   defaults, zeroes the count and puts the sequencer in idle with the bridge off.
`default_nettype none

module encoder_stage_positioner
  import esp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH  = 32,
  parameter int unsigned SETTLE_WIDTH = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // tdata from bit 0: command[2:0], enc_a, enc_b, end_pos_switch, end_neg_switch,
  // mech_switch, index_pulse, hold_pos, hold_neg, zero fill
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [InDataBits-1:0]  in_tdata,
  // tdata from bit 0: bridge_a, bridge_b, duty[7:0], position[31:0], busy_res,
  // count_error, zero fill
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OutDataBits-1:0]      out_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [CfgAddrBits-1:0] cfg_addr,
  input  wire logic [CfgDataBits-1:0] cfg_wdata
);

  logic                          in_valid_r, in_valid_nxt;
  esp_item_t                     item_r;
  logic                          out_valid_r, out_valid_nxt;
  logic                          advance;
  esp_cfg_t                      cfg;
  esp_cnt_ctl_t                  cnt_ctl;
  logic signed [COUNT_WIDTH-1:0] count_cnt, count_r;
  logic                          count_error_r;
  bridge_t                       bridge_r;
  logic [7:0]                    duty_r;
  logic                          busy;
  logic [PosBits-1:0]            position;

  // Advance the held beat whenever the result slot is empty or being drained.
  // The state registers then carry this beat's result until the next advance,
  // so they double as the result register.
  always_comb begin
    advance       = in_valid_r & (~out_valid_r | out_tready);
    in_tready     = ~in_valid_r | advance;
    in_valid_nxt  = (in_tvalid & in_tready) | (in_valid_r & ~advance);
    out_valid_nxt = advance | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holds without reset; load only on an accepted beat.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= esp_item_t'(in_tdata[ItemBits-1:0]);
    end
  end

  esp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_r     (cfg)
  );

  esp_quad #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_quad (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .enc_a         (item_r.enc_a),
    .enc_b         (item_r.enc_b),
    .ctl           (cnt_ctl),
    .count_cnt     (count_cnt),
    .count_r       (count_r),
    .count_error_r (count_error_r)
  );

  esp_seq #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .SETTLE_WIDTH (SETTLE_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (item_r),
    .cfg       (cfg),
    .count_cnt (count_cnt),
    .ctl       (cnt_ctl),
    .bridge_r  (bridge_r),
    .duty_r    (duty_r),
    .busy      (busy)
  );

  // Position shows the low word of the count, sign extended when narrower.
  generate
    if (COUNT_WIDTH >= PosBits) begin : g_pos_trunc
      assign position = count_r[PosBits-1:0];
    end else begin : g_pos_ext
      assign position = PosBits'(count_r);
    end
  endgenerate

  always_comb begin
    out_tvalid = out_valid_r;
    out_tdata  = {4'b0000, count_error_r, busy, position, duty_r, bridge_r};
  end

endmodule

`default_nettype wire

/* src/esp_checker.sv */
`default_nettype none

module esp_checker
  import esp_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OutDataBits-1:0] out_tdata
);

  // Never drive both bridge inputs high.
  a_bridge_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("bridge inputs both high");

  // An idle result always shows the bridge stopped.
  a_idle_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[42]) |-> (out_tdata[1:0] == 2'b00))
    else $error("bridge driven while idle");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result beat changed under stall");

  // No result right after reset.
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind encoder_stage_positioner esp_checker u_esp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
